/* rtl/core/swhfr_pkg.sv */
// ----------------------------------------------------------------------------
// swhfr_pkg
// types and constants shared by the single-wire frame receiver
// ----------------------------------------------------------------------------
package swhfr_pkg;

    localparam int FRAME_BITS     = 40;
    localparam int CNT_W          = 6;
    localparam int FIRST_BIT_EDGE = 3;
    localparam int EDGE_SATURATE  = 43;
    localparam logic [7:0]  THRESH_RESET  = 8'd50;
    localparam logic [15:0] TEMP_MAG_MASK = 16'h7FFF;
    localparam logic [15:0] SUM_MASK      = 16'h00FF;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        OP_TRIGGER = 2'd0,
        OP_EDGE    = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_TRIG_OK   = 3'd0,
        ST_TRIG_BUSY = 3'd1,
        ST_EDGE      = 3'd2,
        ST_GOOD      = 3'd3,
        ST_CRC_ERR   = 3'd4,
        ST_TO_ABORT  = 3'd5,
        ST_TO_IDLE   = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        pin_level;
        logic [31:0] time_us;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic               busy_res;
        logic [15:0]        humidity_tenths;
        logic signed [15:0] temperature_tenths;
        logic [5:0]         edges_seen;
    } t_out_item;

    typedef struct packed {
        logic        good;
        logic [15:0] humidity;
        logic [15:0] temperature;
    } t_dec;

endpackage

/* rtl/core/swhfr_apb_regs.sv */
// ----------------------------------------------------------------------------
// swhfr_apb_regs
// apb register file holding the bit threshold
// ----------------------------------------------------------------------------
module swhfr_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swhfr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swhfr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swhfr_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [7:0]                     o_threshold
);
    import swhfr_pkg::*;

    logic [7:0] r_threshold;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (wr_en) begin
            r_threshold <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_THRESHOLD) begin
            prdata = {{(APB_DATA_W-8){1'b0}}, r_threshold};
        end
    end

    assign o_threshold = r_threshold;

endmodule

/* rtl/core/swhfr_frame_dec.sv */
// ----------------------------------------------------------------------------
// swhfr_frame_dec
// splits a 40-bit frame into humidity, signed temperature and checksum check
// ----------------------------------------------------------------------------
module swhfr_frame_dec (
    input  logic [swhfr_pkg::FRAME_BITS-1:0] i_frame,
    output swhfr_pkg::t_dec                  o_dec
);
    import swhfr_pkg::*;

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [9:0]  sum;
    logic [15:0] raw_t;
    logic [15:0] mag;

    always_comb begin
        b0    = i_frame[39:32];
        b1    = i_frame[31:24];
        b2    = i_frame[23:16];
        b3    = i_frame[15:8];
        b4    = i_frame[7:0];
        sum   = 10'(b0) + 10'(b1) + 10'(b2) + 10'(b3);
        raw_t = {b2, b3};
        mag   = raw_t & TEMP_MAG_MASK;
        o_dec.good        = ({8'd0, b4} == ({6'd0, sum} & SUM_MASK));
        o_dec.humidity    = {b0, b1};
        o_dec.temperature = b2[7] ? (16'd0 - mag) : mag;
    end

endmodule

/* rtl/core/swhfr_event_core.sv */
// ----------------------------------------------------------------------------
// swhfr_event_core
// read state and per-event update: trigger, timeout, edge timing, bit shift, decode
// ----------------------------------------------------------------------------
module swhfr_event_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  swhfr_pkg::t_in_item  i_item,
    input  logic [7:0]           i_threshold,
    output swhfr_pkg::t_out_item o_result
);
    import swhfr_pkg::*;

    logic                  r_busy, n_busy;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [TIME_WIDTH-1:0] r_last, n_last;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic [15:0]           r_hum, n_hum;
    logic [15:0]           r_temp, n_temp;

    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  bit_val;
    logic                  in_window;
    logic [FRAME_BITS-1:0] shifted;
    t_dec                  dec;
    t_status               status;

    assign now       = TIME_WIDTH'(i_item.time_us);
    assign elapsed   = now - r_last;
    assign bit_val   = elapsed > TIME_WIDTH'(i_threshold);
    assign in_window = (r_cnt >= CNT_W'(FIRST_BIT_EDGE)) && (r_cnt < CNT_W'(EDGE_SATURATE));
    assign shifted   = {r_frame[FRAME_BITS-2:0], bit_val};

    swhfr_frame_dec u_dec (
        .i_frame (shifted),
        .o_dec   (dec)
    );

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_frame = r_frame;
        n_hum   = r_hum;
        n_temp  = r_temp;
        status  = ST_TO_IDLE;
        case (i_item.opcode)
            OP_TRIGGER: begin
                if (r_busy) begin
                    status = ST_TRIG_BUSY;
                end else begin
                    n_cnt  = '0;
                    n_busy = 1'b1;
                    n_last = now;
                    status = ST_TRIG_OK;
                end
            end
            OP_EDGE: begin
                status = ST_EDGE;
                if (!i_item.pin_level) begin
                    if (in_window) begin
                        n_frame = shifted;
                        if (r_cnt == CNT_W'(EDGE_SATURATE - 1)) begin
                            n_busy = 1'b0;
                            if (dec.good) begin
                                n_hum  = dec.humidity;
                                n_temp = dec.temperature;
                                status = ST_GOOD;
                            end else begin
                                status = ST_CRC_ERR;
                            end
                        end
                    end
                    if (r_cnt < CNT_W'(EDGE_SATURATE)) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                n_last = now;
            end
            OP_TIMEOUT: begin
                if (r_busy) begin
                    n_busy = 1'b0;
                    status = ST_TO_ABORT;
                end
            end
            default: begin
                status = ST_TO_IDLE;
            end
        endcase
        o_result.status             = status;
        o_result.busy_res           = n_busy;
        o_result.humidity_tenths    = n_hum;
        o_result.temperature_tenths = n_temp;
        o_result.edges_seen         = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_last  <= '0;
            r_frame <= '0;
            r_hum   <= '0;
            r_temp  <= '0;
        end else if (i_fire) begin
            r_busy  <= n_busy;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_frame <= n_frame;
            r_hum   <= n_hum;
            r_temp  <= n_temp;
        end
    end

`ifndef SYNTHESIS
    a_cnt_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(EDGE_SATURATE))
        else $error("falling edge count past saturation");

    a_trigger_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.opcode == OP_TRIGGER) && !r_busy |=> r_busy && (r_cnt == '0))
        else $error("accepted trigger did not start a read");

    a_timeout_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.opcode == OP_TIMEOUT) |=> !r_busy)
        else $error("timeout left the read busy");

    a_decode_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (i_item.opcode == OP_EDGE) && !i_item.pin_level
        && (r_cnt == CNT_W'(EDGE_SATURATE - 1)) |=> !r_busy && (r_cnt == CNT_W'(EDGE_SATURATE)))
        else $error("last frame edge did not end the read");
`endif

endmodule

/* rtl/core/single_wire_humidity_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// single_wire_humidity_frame_receiver_core
// rebuilds a 40-bit humidity/temperature frame from timestamped pin events
//
// channel   dir  handshake            payload
// in        in   i_in_valid/o_in_stall   t_in_item  (opcode, pin_level, time_us)
// out       out  o_out_valid/i_out_stall t_out_item (status .. edges_seen)
// cfg       in   apb psel/penable        bit_threshold_us at byte address 0
//
// one event per cycle sustained while the output does not stall;
// an input register feeds the event logic, which writes state and the result
// register in the same edge
// synchronous active-low reset clears state, threshold returns to 50
// output stall holds the result and backs up into the input register
// ----------------------------------------------------------------------------
module single_wire_humidity_frame_receiver_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  swhfr_pkg::t_in_item              i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output swhfr_pkg::t_out_item             o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [swhfr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swhfr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swhfr_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import swhfr_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  result;
    logic [7:0] threshold;
    logic       fire;
    logic       in_xfer;

    assign fire        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !fire;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    swhfr_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (threshold)
    );

    swhfr_event_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .i_threshold (threshold),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= result;
        end
    end

endmodule

/* tb/single_wire_humidity_frame_receiver_core_tb.sv */
// ----------------------------------------------------------------------------
// single_wire_humidity_frame_receiver_core_tb
// self-checking bench for the single-wire humidity/temperature frame receiver
//
// drives trigger, pin edge and timeout events with random gaps, rebuilds the
// expected status report for every input transfer in a scoreboard that keeps
// its own copy of the receiver state, and checks each output transfer in order.
// most events form timed 40-bit frames with random content and bit threshold;
// some frames are cut by a timeout or a second trigger, the rest is noise.
// the bit threshold is rewritten over the apb port between drained phases.
// ----------------------------------------------------------------------------
module single_wire_humidity_frame_receiver_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import swhfr_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int NUM_PHASES     = 5;
    localparam int PHASE_ITEMS    = 140;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTED   = 10;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] THRESH_ADDR = APB_ADDR_W'(4 * REG_THRESHOLD);

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_NEG_ZERO,
        FILL_BAD_SUM
    } t_fill;

    class frame_report_checker;
        logic [7:0]  threshold;
        logic        busy;
        logic [5:0]  falls;
        logic [31:0] last_time;
        logic [39:0] shift_reg;
        logic [15:0] hum_latch;
        logic [15:0] temp_latch;
        t_out_item   expected_reports[$];
        int          mismatch_count;

        function new();
            threshold      = THRESH_RESET;
            busy           = 1'b0;
            falls          = '0;
            last_time      = '0;
            shift_reg      = '0;
            hum_latch      = '0;
            temp_latch     = '0;
            mismatch_count = 0;
        endfunction

        function void set_threshold(logic [7:0] val);
            threshold = val;
        endfunction

        function void flag_error(string msg);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED) begin
                $display("%s", msg);
            end
        endfunction

        function t_status decode_frame();
            logic [7:0]  b0, b1, b2, b3, b4, sum;
            logic [15:0] mag;
            t_status     st;
            b0  = shift_reg[39:32];
            b1  = shift_reg[31:24];
            b2  = shift_reg[23:16];
            b3  = shift_reg[15:8];
            b4  = shift_reg[7:0];
            sum = b0 + b1 + b2 + b3;
            mag = {b2, b3} & TEMP_MAG_MASK;
            st  = ST_CRC_ERR;
            if (b4 == sum) begin
                hum_latch  = {b0, b1};
                temp_latch = b2[7] ? (16'd0 - mag) : mag;
                st         = ST_GOOD;
            end
            busy = 1'b0;
            return st;
        endfunction

        function void note_event(t_in_item ev);
            t_status     st;
            t_out_item   rep;
            logic [31:0] elapsed;
            st = ST_TO_IDLE;
            case (ev.opcode)
                OP_TRIGGER: begin
                    if (busy) begin
                        st = ST_TRIG_BUSY;
                    end else begin
                        falls     = '0;
                        busy      = 1'b1;
                        last_time = ev.time_us;
                        st        = ST_TRIG_OK;
                    end
                end
                OP_EDGE: begin
                    elapsed = ev.time_us - last_time;
                    st      = ST_EDGE;
                    if (!ev.pin_level) begin
                        if (falls >= FIRST_BIT_EDGE && falls < EDGE_SATURATE) begin
                            shift_reg = {shift_reg[38:0], elapsed > {24'd0, threshold}};
                            if (falls == EDGE_SATURATE - 1) begin
                                st = decode_frame();
                            end
                        end
                        if (falls < EDGE_SATURATE) begin
                            falls = falls + 6'd1;
                        end
                    end
                    last_time = ev.time_us;
                end
                OP_TIMEOUT: begin
                    if (busy) begin
                        busy = 1'b0;
                        st   = ST_TO_ABORT;
                    end
                end
                default: st = ST_TO_IDLE;
            endcase
            rep.status             = st;
            rep.busy_res           = busy;
            rep.humidity_tenths    = hum_latch;
            rep.temperature_tenths = temp_latch;
            rep.edges_seen         = falls;
            expected_reports.push_back(rep);
        endfunction

        function void check_report(t_out_item got);
            t_out_item exp_rep;
            if (expected_reports.size() == 0) begin
                flag_error($sformatf("unexpected report: st=%0d busy=%0d hum=%h temp=%h edges=%0d",
                                     got.status, got.busy_res, got.humidity_tenths,
                                     got.temperature_tenths, got.edges_seen));
                return;
            end
            exp_rep = expected_reports.pop_front();
            if (got.status !== exp_rep.status || got.busy_res !== exp_rep.busy_res
                    || got.humidity_tenths !== exp_rep.humidity_tenths
                    || got.temperature_tenths !== exp_rep.temperature_tenths
                    || got.edges_seen !== exp_rep.edges_seen) begin
                flag_error($sformatf({"report mismatch: expected st=%0d busy=%0d hum=%h ",
                                      "temp=%h edges=%0d, got st=%0d busy=%0d hum=%h ",
                                      "temp=%h edges=%0d"},
                                     exp_rep.status, exp_rep.busy_res,
                                     exp_rep.humidity_tenths, exp_rep.temperature_tenths,
                                     exp_rep.edges_seen, got.status, got.busy_res,
                                     got.humidity_tenths, got.temperature_tenths,
                                     got.edges_seen));
            end
        endfunction
    endclass

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    frame_report_checker sb;
    logic [31:0]         now_us     = '0;
    logic [7:0]          cur_thresh = THRESH_RESET;
    bit                  quiet      = 1'b0;
    bit                  src_calm   = 1'b0;
    bit                  rx_calm    = 1'b0;
    bit                  hold_req   = 1'b0;
    int                  items_sent = 0;
    int                  idle_cycles = 0;

    single_wire_humidity_frame_receiver_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            sb.check_report(out_item);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (!quiet && !rx_calm && $urandom_range(0, 11) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_event(input logic [1:0] op, input logic level,
                              input logic [31:0] stamp);
        t_in_item ev;
        ev.opcode    = op;
        ev.pin_level = level;
        ev.time_us   = stamp;
        if (!quiet && !src_calm && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        do @(posedge i_clk); while (in_stall);
        sb.note_event(ev);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int cut_at);
        logic [7:0]  b0, b1, b2, b3, b4;
        logic [39:0] bits;
        logic [31:0] high_us;
        t_fill       fill;
        int          thr;
        int          pick;
        thr  = cur_thresh;
        pick = $urandom_range(0, 7);
        fill = (pick < 4) ? FILL_RANDOM : t_fill'(pick - 3);
        b0 = 8'($urandom);
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        case (fill)
            FILL_ZERO: begin
                b0 = 8'h00; b1 = 8'h00; b2 = 8'h00; b3 = 8'h00;
            end
            FILL_ONES: begin
                b0 = 8'hFF; b1 = 8'hFF; b2 = 8'hFF; b3 = 8'hFF;
            end
            FILL_NEG_ZERO: begin
                b2 = 8'h80; b3 = 8'h00;
            end
            default: ;
        endcase
        b4 = b0 + b1 + b2 + b3;
        if (fill == FILL_BAD_SUM) begin
            b4 = b4 ^ 8'($urandom_range(1, 255));
        end
        bits     = {b0, b1, b2, b3, b4};
        src_calm = ($urandom_range(0, 3) == 0);
        rx_calm  = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) begin
            now_us = 32'hFFFF_F000 + $urandom_range(0, 4095);
        end else begin
            now_us = $urandom;
        end
        send_event(OP_TRIGGER, 1'($urandom_range(0, 1)), now_us);
        for (int k = 0; k < EDGE_SATURATE; k++) begin
            now_us = now_us + $urandom_range(1, 90);
            send_event(OP_EDGE, 1'b1, now_us);
            if (k >= FIRST_BIT_EDGE) begin
                high_us = bits[FRAME_BITS - 1 - (k - FIRST_BIT_EDGE)]
                          ? $urandom_range(thr + 1, thr + 80) : $urandom_range(0, thr);
            end else begin
                high_us = $urandom_range(20, 180);
            end
            now_us = now_us + high_us;
            send_event(OP_EDGE, 1'b0, now_us);
            if (k == cut_at) begin
                send_event($urandom_range(0, 1) ? OP_TIMEOUT : OP_TRIGGER,
                           1'($urandom_range(0, 1)), now_us + $urandom_range(0, 500));
            end
        end
    endtask

    task automatic run_mix(input int target);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                send_frame(-1);
            end else if (pick < 8) begin
                send_frame($urandom_range(0, EDGE_SATURATE - 1));
            end else if (pick == 8) begin
                repeat ($urandom_range(1, 8)) begin
                    send_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom);
                end
            end else begin
                // trailing edges past the last frame bit, then an idle timeout
                send_frame(-1);
                repeat ($urandom_range(1, 3)) begin
                    now_us = now_us + $urandom_range(1, 300);
                    send_event(OP_EDGE, 1'b0, now_us);
                end
                send_event(OP_TIMEOUT, 1'b0, now_us);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESH_ADDR;
        pwdata  <= APB_DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_threshold(val);
        cur_thresh = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_threshold();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THRESH_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(cur_thresh)) begin
            sb.flag_error($sformatf("threshold readback: expected %h, got %h",
                                    cur_thresh, prdata));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle events, wrap-around elapsed time, threshold boundary, aborts
        send_event(OP_TIMEOUT, 1'b0, 32'h0000_0000);
        send_event(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);
        send_event(OP_EDGE, 1'b1, 32'h0000_0000);
        send_event(OP_EDGE, 1'b0, 32'hFFFF_FFFF);
        send_event(OP_TRIGGER, 1'b0, 32'hFFFF_FFF0);
        send_event(OP_TRIGGER, 1'b1, 32'h0000_0005);
        send_event(OP_EDGE, 1'b1, 32'h0000_0010);
        send_event(OP_EDGE, 1'b0, 32'h0000_0043);
        send_event(OP_EDGE, 1'b0, 32'h0000_0043);
        send_event(OP_EDGE, 1'b0, 32'h0000_0043);
        send_event(OP_EDGE, 1'b0, 32'h0000_0075);
        send_event(OP_EDGE, 1'b0, 32'h0000_00A8);
        send_event(OP_TIMEOUT, 1'b1, 32'h0000_00B0);
        send_event(OP_TIMEOUT, 1'b0, 32'h0000_00C0);
        send_event(OP_UNUSED, 1'b0, 32'h8000_0000);
        send_event(OP_TRIGGER, 1'b1, 32'h5555_AAAA);
        send_event(OP_EDGE, 1'b0, 32'hAAAA_5555);
        send_event(OP_TIMEOUT, 1'b1, 32'h7FFF_FFFF);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                write_threshold(ph == 1 ? 8'h00 : ph == 2 ? 8'hFF : 8'($urandom));
                read_threshold();
            end
            quiet    = (ph == NUM_PHASES - 1);
            hold_req = (ph == 2);
            run_mix(PHASE_ITEMS);
        end
        drain();

        if (sb.mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
